FILE: rtl/opc_pkg.sv
// opc_pkg: shared constants, token type and field widths for offset_pair_counter.
// No dependencies; compile first.
package opc_pkg;

   // sizing
   localparam int MAX_ITEMS   = 1024;
   localparam int VALUE_BITS  = 16;

   // fixed field widths
   localparam int FIELD_BITS  = 16;
   localparam int OFFSET_BITS = 18;
   localparam int PAIRS_BITS  = 10;
   localparam int TOTAL_BITS  = 19;

   // derived widths
   localparam int DIFF_BITS   = VALUE_BITS + 1;
   localparam int BOUND_BITS  = ((DIFF_BITS > OFFSET_BITS) ? DIFF_BITS : OFFSET_BITS) + 1;
   localparam int SLOT_BITS   = $clog2(MAX_ITEMS + 1);
   localparam int CNT_BITS    = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;

   // one request in flight along the cell row
   typedef struct packed {
      logic                         valid;
      logic                         last;
      logic                         full;
      logic [SLOT_BITS-1:0]         slot;
      logic signed [DIFF_BITS-1:0]  diff;
      logic signed [BOUND_BITS-1:0] bound;
      logic [CNT_BITS-1:0]          count;
   } tok_type;

endpackage

FILE: rtl/opc_if.sv
// opc_if: request and response channel interfaces (valid/ready plus payload).
// Depends on opc_pkg.
interface opc_req_if;
   import opc_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] first_value;
   logic signed [FIELD_BITS-1:0] second_value;
   logic                         last_item;

   modport source (output valid, first_value, second_value, last_item, input ready);
   modport sink   (input valid, first_value, second_value, last_item, output ready);
endinterface

interface opc_rsp_if;
   import opc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PAIRS_BITS-1:0] pairs_added;
   logic [TOTAL_BITS-1:0] total_pairs;
   logic                  full_flag;
   logic                  set_done;

   modport source (output valid, pairs_added, total_pairs, full_flag, set_done, input ready);
   modport sink   (input valid, pairs_added, total_pairs, full_flag, set_done, output ready);
endinterface

FILE: rtl/opc_entry.sv
// opc_entry: entry stage; forms difference and bound, assigns the store slot.
// Depends on opc_pkg.
module opc_entry (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  logic                                   req_valid,
   input  logic signed [opc_pkg::FIELD_BITS-1:0]  first_value,
   input  logic signed [opc_pkg::FIELD_BITS-1:0]  second_value,
   input  logic                                   last_item,
   input  logic signed [opc_pkg::OFFSET_BITS-1:0] offset,
   output opc_pkg::tok_type                       tok_out,
   output logic [opc_pkg::SLOT_BITS-1:0]          slot_level
);
   import opc_pkg::*;

   logic [SLOT_BITS-1:0]            slot_ff, slot_in;
   tok_type                         tok_ff, tok_in;
   logic [VALUE_BITS+FIELD_BITS-1:0] a_wide, b_wide;
   logic signed [VALUE_BITS-1:0]    a_val, b_val;
   logic signed [DIFF_BITS-1:0]     diff;
   logic                            is_full;

   // raw field, reinterpreted as a VALUE_BITS two's complement number
   assign a_wide  = {{VALUE_BITS{1'b0}}, first_value};
   assign b_wide  = {{VALUE_BITS{1'b0}}, second_value};
   assign a_val   = signed'(a_wide[VALUE_BITS-1:0]);
   assign b_val   = signed'(b_wide[VALUE_BITS-1:0]);
   assign diff    = DIFF_BITS'(a_val) - DIFF_BITS'(b_val);
   assign is_full = (slot_ff == SLOT_BITS'(MAX_ITEMS));

   always_comb begin
      tok_in       = tok_ff;
      slot_in      = slot_ff;
      tok_in.valid = req_valid;
      if (req_valid) begin
         tok_in.last  = last_item;
         tok_in.full  = is_full;
         tok_in.slot  = slot_ff;
         tok_in.diff  = diff;
         tok_in.bound = BOUND_BITS'(diff) + BOUND_BITS'(offset);
         tok_in.count = '0;
         if (last_item) begin
            slot_in = '0;
         end else if (!is_full) begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         slot_ff <= slot_in;
         tok_ff  <= tok_in;
      end
   end

   assign tok_out    = tok_ff;
   assign slot_level = slot_ff;

endmodule

FILE: rtl/opc_cell.sv
// opc_cell: one store entry; counts and forwards the passing request token.
// Depends on opc_pkg.
module opc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [opc_pkg::SLOT_BITS-1:0] cell_index,
   input  opc_pkg::tok_type              tok_in_data,
   output opc_pkg::tok_type              tok_out
);
   import opc_pkg::*;

   logic signed [DIFF_BITS-1:0] diff_ff, diff_in;
   tok_type                     tok_ff, tok_in;
   logic                        live, hit, own;

   assign live = tok_in_data.valid && !tok_in_data.full;
   // entries below the token's slot were written earlier in the same set
   assign hit  = live && (cell_index < tok_in_data.slot) &&
                 ($signed(diff_ff) <= $signed(tok_in_data.bound));
   assign own  = live && (cell_index == tok_in_data.slot);

   always_comb begin
      tok_in  = tok_in_data;
      diff_in = diff_ff;
      if (hit) begin
         tok_in.count = tok_in_data.count + 1'b1;
      end
      if (own) begin
         diff_in = tok_in_data.diff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff <= diff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

FILE: rtl/opc_tally.sv
// opc_tally: end of the cell row; running set total and response register.
// Depends on opc_pkg.
module opc_tally (
   input  logic                           clock,
   input  logic                           reset,
   input  opc_pkg::tok_type               tail,
   input  logic                           rsp_ready,
   output logic                           adv,
   output logic                           rsp_valid,
   output logic [opc_pkg::PAIRS_BITS-1:0] pairs_added,
   output logic [opc_pkg::TOTAL_BITS-1:0] total_pairs,
   output logic                           full_flag,
   output logic                           set_done
);
   import opc_pkg::*;

   logic                             valid_ff;
   logic [PAIRS_BITS-1:0]            pairs_ff;
   logic [TOTAL_BITS-1:0]            sum_ff, set_total_ff, set_total_in, sum;
   logic                             full_ff, done_ff;
   logic [CNT_BITS+PAIRS_BITS-1:0]   cnt_p;
   logic [CNT_BITS+TOTAL_BITS-1:0]   cnt_t;

   assign adv   = !valid_ff || rsp_ready;
   assign cnt_p = {{PAIRS_BITS{1'b0}}, tail.count};
   assign cnt_t = {{TOTAL_BITS{1'b0}}, tail.count};
   assign sum   = set_total_ff + cnt_t[TOTAL_BITS-1:0];

   always_comb begin
      set_total_in = set_total_ff;
      if (tail.valid) begin
         set_total_in = tail.last ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         set_total_ff <= '0;
      end else if (adv) begin
         valid_ff     <= tail.valid;
         set_total_ff <= set_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tail.valid) begin
         pairs_ff <= cnt_p[PAIRS_BITS-1:0];
         sum_ff   <= sum;
         full_ff  <= tail.full;
         done_ff  <= tail.last;
      end
   end

   assign rsp_valid   = valid_ff;
   assign pairs_added = pairs_ff;
   assign total_pairs = sum_ff;
   assign full_flag   = full_ff;
   assign set_done    = done_ff;

endmodule

FILE: rtl/offset_pair_counter.sv
// offset_pair_counter: top level; entry stage, row of MAX_ITEMS cells, tally.
// Depends on opc_pkg, opc_if, opc_entry, opc_cell, opc_tally.
//
//   channel | dir | handshake         | contents
//   --------+-----+-------------------+------------------------------------------
//   req_ch  | in  | valid/ready       | first_value, second_value, last_item
//   rsp_ch  | out | valid/ready       | pairs_added, total_pairs, full_flag, set_done
//   csr     | in  | csr_wr_en         | csr_wr_data = offset_limit (signed 18b)
//
// One request per cycle while the response is not stalled; each request travels
// the cell row one cell a cycle, then the tally register holds its response.
// Request k of a set writes its difference into cell k as it passes; later
// requests follow it along the row, so they always see it.
// Reset (synchronous) empties the row and clears slot counter and set total;
// stored differences are not cleared, cells are read only below the slot.
// A stalled response freezes the whole row and the entry stage together.
module offset_pair_counter (
   input  logic                                   clock,
   input  logic                                   reset,
   opc_req_if.sink                                req_ch,
   opc_rsp_if.source                              rsp_ch,
   input  logic                                   csr_wr_en,
   input  logic signed [opc_pkg::OFFSET_BITS-1:0] csr_wr_data
);
   import opc_pkg::*;

   logic signed [OFFSET_BITS-1:0] offset_ff;
   logic                          adv;
   logic [SLOT_BITS-1:0]          slot_level;
   tok_type                       chain [0:MAX_ITEMS];

   // offset register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   // one global advance: the row moves when the response register can load
   assign req_ch.ready = adv;

   opc_entry u_entry (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .req_valid    (req_ch.valid),
      .first_value  (req_ch.first_value),
      .second_value (req_ch.second_value),
      .last_item    (req_ch.last_item),
      .offset       (offset_ff),
      .tok_out      (chain[0]),
      .slot_level   (slot_level)
   );

   // cell k holds the difference of request k of the current set
   for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
      opc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .adv         (adv),
         .cell_index  (SLOT_BITS'(k)),
         .tok_in_data (chain[k]),
         .tok_out     (chain[k+1])
      );
   end

   opc_tally u_tally (
      .clock       (clock),
      .reset       (reset),
      .tail        (chain[MAX_ITEMS]),
      .rsp_ready   (rsp_ch.ready),
      .adv         (adv),
      .rsp_valid   (rsp_ch.valid),
      .pairs_added (rsp_ch.pairs_added),
      .total_pairs (rsp_ch.total_pairs),
      .full_flag   (rsp_ch.full_flag),
      .set_done    (rsp_ch.set_done)
   );

   // an ignored request never reports pairs
   a_full_no_pairs : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.full_flag |-> rsp_ch.pairs_added == '0)
      else $error("pairs reported for an ignored request");

   // slot counter stays within capacity
   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      slot_level <= SLOT_BITS'(MAX_ITEMS))
      else $error("slot counter beyond capacity");

   // a request cannot match more entries than precede it in its set
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      chain[MAX_ITEMS].valid |-> (SLOT_BITS+1)'(chain[MAX_ITEMS].count) <=
                                 (SLOT_BITS+1)'(chain[MAX_ITEMS].slot))
      else $error("pair count exceeds earlier entries");

   // no response straight out of reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

endmodule
